// ----- sv/bpss_pkg.sv -----
package bpss_pkg;

  // Sample filter geometry
  localparam int unsigned SampleDepth = 8;
  localparam int unsigned PtrW        = $clog2(SampleDepth);
  localparam int unsigned SampleW     = 10;
  localparam int unsigned SumW        = 13;
  localparam int unsigned PeriodW     = 9;
  localparam int unsigned TimerW      = 16;
  localparam int unsigned StateW      = 4;
  localparam int unsigned CfgAddrW    = 3;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [SampleW-1:0] AdcMax   = SampleW'(1023);
  localparam logic [TimerW-1:0]  TimerMax = {TimerW{1'b1}};

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] CfgLowSum     = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgSafeSum    = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgRefresh    = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgInitHold   = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgEntryHold  = 3'd4;
  localparam logic [CfgAddrW-1:0] CfgVentHold   = 3'd5;
  localparam logic [CfgAddrW-1:0] CfgRecovHold  = 3'd6;
  localparam logic [CfgAddrW-1:0] CfgFaultHold  = 3'd7;

  // Configuration reset values
  localparam logic [SumW-1:0]    RstLowSum    = SumW'(1473);
  localparam logic [SumW-1:0]    RstSafeSum   = SumW'(1146);
  localparam logic [PeriodW-1:0] RstRefresh   = PeriodW'(300);
  localparam logic [TimerW-1:0]  RstInitHold  = TimerW'(2000);
  localparam logic [TimerW-1:0]  RstEntryHold = TimerW'(1000);
  localparam logic [TimerW-1:0]  RstVentHold  = TimerW'(5000);
  localparam logic [TimerW-1:0]  RstRecovHold = TimerW'(3000);
  localparam logic [TimerW-1:0]  RstFaultHold = TimerW'(10000);

  typedef struct packed {
    logic [SumW-1:0]    low_sum;
    logic [SumW-1:0]    safe_sum;
    logic [PeriodW-1:0] refresh_period;
    logic [TimerW-1:0]  init_hold;
    logic [TimerW-1:0]  entry_hold;
    logic [TimerW-1:0]  vent_hold;
    logic [TimerW-1:0]  recov_hold;
    logic [TimerW-1:0]  fault_hold;
  } cfg_t;

  typedef struct packed {
    logic [StateW-1:0] state_code;
    logic              relief_open;
    logic              ignition_on;
    logic              emerg_flag;
  } seq_out_t;

  // Saturating timer increment
  function automatic logic [TimerW-1:0] sat_inc(input logic [TimerW-1:0] v);
    return (v == TimerMax) ? v : v + TimerW'(1);
  endfunction

endpackage

// ----- sv/bpss_filter.sv -----
module bpss_filter
  import bpss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               sample_valid_i,
  input  logic [SampleW-1:0] pressure_sample_i,
  input  logic [PeriodW-1:0] refresh_period_i,
  output logic [SumW-1:0]    held_sum_o
);

  logic [SampleW-1:0] ring_q [SampleDepth];
  logic [PtrW-1:0]    ptr_q, ptr_d;
  logic [SumW-1:0]    run_q, run_d;
  logic [SumW-1:0]    held_q, held_d;
  logic [PeriodW-1:0] cnt_q, cnt_d;
  logic [SampleW-1:0] smp;
  logic [PeriodW:0]   cnt_inc;

  // Clamp the sample and work out the new running sum
  always_comb begin
    smp   = (pressure_sample_i > AdcMax) ? AdcMax : pressure_sample_i;
    run_d = run_q;
    ptr_d = ptr_q;
    if (sample_valid_i) begin
      run_d = run_q - SumW'(ring_q[ptr_q]) + SumW'(smp);
      ptr_d = (ptr_q == PtrW'(SampleDepth - 1)) ? '0 : ptr_q + PtrW'(1);
    end
  end

  // Refresh the filtered sum once per period
  always_comb begin
    cnt_inc = {1'b0, cnt_q} + (PeriodW+1)'(1);
    if (cnt_inc >= {1'b0, refresh_period_i}) begin
      held_d = run_d;
      cnt_d  = '0;
    end else begin
      held_d = held_q;
      cnt_d  = cnt_inc[PeriodW-1:0];
    end
  end

  assign held_sum_o = held_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SampleDepth; i++) ring_q[i] <= '0;
      ptr_q  <= '0;
      run_q  <= '0;
      held_q <= '0;
      cnt_q  <= '0;
    end else if (step_i) begin
      if (sample_valid_i) ring_q[ptr_q] <= smp;
      ptr_q  <= ptr_d;
      run_q  <= run_d;
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- sv/bpss_sequencer.sv -----
module bpss_sequencer
  import bpss_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            master_switch_i,
  input  logic            ignition_request_i,
  input  logic            ignition_enable_i,
  input  logic [SumW-1:0] held_sum_i,
  input  cfg_t            cfg_i,
  output seq_out_t        result_o
);

  typedef enum logic [StateW-1:0] {
    StInit   = 4'd0,
    StWait   = 4'd1,
    StCheck  = 4'd2,
    StOper   = 4'd3,
    StEntry  = 4'd4,
    StActive = 4'd5,
    StDepr   = 4'd6,
    StRecov  = 4'd7,
    StFault  = 4'd8
  } state_e;

  state_e            state_q, state_d, next;
  logic [TimerW-1:0] stimer_q, stimer_d;
  logic [TimerW-1:0] htimer_q, htimer_d;
  logic              hrun_q, hrun_d;
  logic              relief_q, relief_d;
  logic              emerg_q, emerg_d;
  logic              ign;
  logic              vented;

  assign vented = (held_sum_i <= cfg_i.safe_sum);

  // Next state, outputs and hold timer for this item
  always_comb begin
    htimer_d = hrun_q ? sat_inc(htimer_q) : htimer_q;
    hrun_d   = hrun_q;
    relief_d = relief_q;
    emerg_d  = emerg_q;
    ign      = 1'b0;
    next     = state_q;
    case (state_q)
      StInit: begin
        relief_d = 1'b0;
        emerg_d  = 1'b0;
        if (stimer_q > cfg_i.init_hold) next = StWait;
      end
      StWait: begin
        relief_d = 1'b0;
        if (master_switch_i) next = StCheck;
      end
      StCheck: begin
        next = (held_sum_i >= cfg_i.low_sum) ? StOper : StEntry;
      end
      StOper: begin
        ign = ignition_request_i && ignition_enable_i && !emerg_q;
        if (!master_switch_i) next = StFault;
        else if (held_sum_i < cfg_i.low_sum) next = StEntry;
      end
      StEntry: begin
        relief_d = 1'b1;
        emerg_d  = 1'b1;
        if (stimer_q > cfg_i.entry_hold) next = StActive;
      end
      StActive: begin
        relief_d = 1'b1;
        emerg_d  = 1'b1;
        if (vented) next = StDepr;
      end
      StDepr: begin
        relief_d = 1'b1;
        if (vented && master_switch_i) begin
          if (!hrun_q) begin
            hrun_d   = 1'b1;
            htimer_d = '0;
          end
          if (htimer_d > cfg_i.vent_hold) next = StRecov;
        end
      end
      StRecov: begin
        relief_d = 1'b0;
        emerg_d  = 1'b0;
        if (stimer_q > cfg_i.recov_hold) next = StWait;
      end
      StFault: begin
        relief_d = 1'b1;
        if (master_switch_i) begin
          if (!hrun_q) begin
            hrun_d   = 1'b1;
            htimer_d = '0;
          end
          if (htimer_d > cfg_i.fault_hold) next = StWait;
        end
      end
      default: begin
        next = StInit;
      end
    endcase

    // A state change restarts every timer
    state_d = next;
    if (next != state_q) begin
      stimer_d = '0;
      hrun_d   = 1'b0;
      htimer_d = '0;
    end else begin
      stimer_d = sat_inc(stimer_q);
    end
  end

  assign result_o.state_code  = state_d;
  assign result_o.relief_open = relief_d;
  assign result_o.ignition_on = ign;
  assign result_o.emerg_flag  = emerg_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StInit;
      stimer_q <= '0;
      htimer_q <= '0;
      hrun_q   <= 1'b0;
      relief_q <= 1'b0;
      emerg_q  <= 1'b0;
    end else if (step_i) begin
      state_q  <= state_d;
      stimer_q <= stimer_d;
      htimer_q <= htimer_d;
      hrun_q   <= hrun_d;
      relief_q <= relief_d;
      emerg_q  <= emerg_d;
    end
  end

endmodule

// ----- sv/brake_pressure_safety_sequencer_core.sv -----
// Brake pressure safety sequencer. Each input item is one millisecond tick carrying the
// switch levels and, when tuser is set, a tank pressure sample. The block filters the
// samples over an eight-entry ring, refreshes the filtered sum once per refresh period
// and steps a nine-state safety sequencer, giving exactly one result item per tick. An
// item is captured in an input register and its result is written into the result
// register once that register is free or being emptied. The block takes one item every
// clock cycle and only slows when the result register is held by the downstream side.
// Configuration writes are taken on any cycle with cfg_we_i high and act on the items
// processed after them.
module brake_pressure_safety_sequencer_core
  import bpss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input ticks
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [0] master_switch, [1] ignition_request, [2] ignition_enable,
  // [12:3] pressure_sample, [15:13] zero
  input  logic [15:0]         s_axis_tdata_i,
  // [0] sample_valid
  input  logic                s_axis_tuser_i,
  // Results
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [3:0] state_code, [4] relief_open, [5] ignition_on, [6] emerg_flag,
  // [19:7] filtered_sum, [23:20] zero
  output logic [23:0]         m_axis_tdata_o,
  // Configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t               cfg_q;
  logic               in_valid_q;
  logic               master_q, req_q, en_q, svalid_q;
  logic [SampleW-1:0] sample_q;
  logic               out_valid_q;
  seq_out_t           res_q;
  logic [SumW-1:0]    sum_q;
  logic               step;
  logic [SumW-1:0]    held_sum;
  seq_out_t           seq_res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_sum        <= RstLowSum;
      cfg_q.safe_sum       <= RstSafeSum;
      cfg_q.refresh_period <= RstRefresh;
      cfg_q.init_hold      <= RstInitHold;
      cfg_q.entry_hold     <= RstEntryHold;
      cfg_q.vent_hold      <= RstVentHold;
      cfg_q.recov_hold     <= RstRecovHold;
      cfg_q.fault_hold     <= RstFaultHold;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgLowSum:    cfg_q.low_sum        <= cfg_wdata_i[SumW-1:0];
        CfgSafeSum:   cfg_q.safe_sum       <= cfg_wdata_i[SumW-1:0];
        CfgRefresh:   cfg_q.refresh_period <= cfg_wdata_i[PeriodW-1:0];
        CfgInitHold:  cfg_q.init_hold      <= cfg_wdata_i[TimerW-1:0];
        CfgEntryHold: cfg_q.entry_hold     <= cfg_wdata_i[TimerW-1:0];
        CfgVentHold:  cfg_q.vent_hold      <= cfg_wdata_i[TimerW-1:0];
        CfgRecovHold: cfg_q.recov_hold     <= cfg_wdata_i[TimerW-1:0];
        CfgFaultHold: cfg_q.fault_hold     <= cfg_wdata_i[TimerW-1:0];
        default: begin
        end
      endcase
    end
  end

  // The held item is processed when the result register is free or being emptied
  assign step            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      master_q <= s_axis_tdata_i[0];
      req_q    <= s_axis_tdata_i[1];
      en_q     <= s_axis_tdata_i[2];
      sample_q <= s_axis_tdata_i[12:3];
      svalid_q <= s_axis_tuser_i;
    end
  end

  bpss_filter u_filter (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .sample_valid_i    (svalid_q),
    .pressure_sample_i (sample_q),
    .refresh_period_i  (cfg_q.refresh_period),
    .held_sum_o        (held_sum)
  );

  bpss_sequencer u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (step),
    .master_switch_i    (master_q),
    .ignition_request_i (req_q),
    .ignition_enable_i  (en_q),
    .held_sum_i         (held_sum),
    .cfg_i              (cfg_q),
    .result_o           (seq_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= seq_res;
      sum_q <= held_sum;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, sum_q, res_q.emerg_flag, res_q.ignition_on,
                            res_q.relief_open, res_q.state_code};

endmodule

// ----- sv/bpss_checker.sv -----
module bpss_checker
  import bpss_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o
);

  // A stalled result holds its contents
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Only the nine defined state codes are reported
  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[3:0] <= 4'd8)
    else $error("undefined state code");

  // Ignition is only granted on a tick that starts in the operational state, which
  // then stays operational or leaves for emergency entry or fault
  a_ign_oper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[5] |->
    m_axis_tdata_o[3:0] == 4'd3 || m_axis_tdata_o[3:0] == 4'd4 ||
    m_axis_tdata_o[3:0] == 4'd8)
    else $error("ignition outside operational state");

  // The emergency active state vents the tank and raises the emergency flag
  a_emerg_relief: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[3:0] == 4'd5
    |-> m_axis_tdata_o[4] && m_axis_tdata_o[6])
    else $error("emergency state without relief or flag");

  // Init keeps the relief valves closed and the emergency flag low
  a_relief_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[3:0] == 4'd0 |-> !m_axis_tdata_o[4] &&
    !m_axis_tdata_o[6])
    else $error("relief open in a quiet state");

endmodule

bind brake_pressure_safety_sequencer_core bpss_checker u_bpss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ----- tb/bpss_tb_pkg.sv -----
`timescale 1ns / 1ps

package bpss_tb_pkg;
  import bpss_pkg::*;

  // Sequencer states as they appear in the state code field.
  typedef enum logic [StateW-1:0] {
    StInit   = 4'd0,
    StWait   = 4'd1,
    StCheck  = 4'd2,
    StOper   = 4'd3,
    StEntry  = 4'd4,
    StActive = 4'd5,
    StDepr   = 4'd6,
    StRecov  = 4'd7,
    StFault  = 4'd8
  } seq_state_e;

  // One result item, unpacked into its fields.
  typedef struct packed {
    logic [StateW-1:0] state_code;
    logic              relief_open;
    logic              ignition_on;
    logic              emerg_flag;
    logic [SumW-1:0]   filtered_sum;
  } tick_output_t;

  class sequencer_scoreboard;
    // Register copy.
    logic [SumW-1:0]    low_sum;
    logic [SumW-1:0]    safe_sum;
    logic [PeriodW-1:0] refresh_period;
    logic [TimerW-1:0]  init_hold;
    logic [TimerW-1:0]  entry_hold;
    logic [TimerW-1:0]  vent_hold;
    logic [TimerW-1:0]  recov_hold;
    logic [TimerW-1:0]  fault_hold;

    // Sequencer and filter state.
    seq_state_e         state;
    int unsigned        state_timer;
    bit                 hold_running;
    int unsigned        hold_timer;
    logic [SampleW-1:0] ring [SampleDepth];
    int unsigned        ring_ptr;
    int unsigned        running_sum;
    int unsigned        held_sum;
    int unsigned        refresh_count;
    bit                 emergency;
    bit                 relief;

    // Outputs predicted for ticks accepted but not yet seen at the result side.
    tick_output_t       outputs_due [$];
    int unsigned        mismatches;

    function new();
      low_sum        = RstLowSum;
      safe_sum       = RstSafeSum;
      refresh_period = RstRefresh;
      init_hold      = RstInitHold;
      entry_hold     = RstEntryHold;
      vent_hold      = RstVentHold;
      recov_hold     = RstRecovHold;
      fault_hold     = RstFaultHold;
      state          = StInit;
      state_timer    = 0;
      hold_running   = 1'b0;
      hold_timer     = 0;
      foreach (ring[i]) ring[i] = '0;
      ring_ptr       = 0;
      running_sum    = 0;
      held_sum       = 0;
      refresh_count  = 0;
      emergency      = 1'b0;
      relief         = 1'b0;
      mismatches     = 0;
    endfunction

    function void set_register(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CfgLowSum:    low_sum        = val[SumW-1:0];
        CfgSafeSum:   safe_sum       = val[SumW-1:0];
        CfgRefresh:   refresh_period = val[PeriodW-1:0];
        CfgInitHold:  init_hold      = val;
        CfgEntryHold: entry_hold     = val;
        CfgVentHold:  vent_hold      = val;
        CfgRecovHold: recov_hold     = val;
        default:      fault_hold     = val;
      endcase
    endfunction

    function int unsigned pending();
      return outputs_due.size();
    endfunction

    // Advances the filter and the sequencer by one tick and queues the output.
    function void note_tick(bit master, bit req, bit en, bit valid,
                            logic [SampleW-1:0] sample);
      seq_state_e         nxt;
      bit                 ign;
      logic [SampleW-1:0] s;
      tick_output_t       o;
      s   = sample;
      ign = 1'b0;

      // The sample enters the ring first.
      if (valid) begin
        if (s > AdcMax) s = AdcMax;
        running_sum    = running_sum - ring[ring_ptr] + s;
        ring[ring_ptr] = s;
        ring_ptr       = (ring_ptr + 1) % SampleDepth;
      end

      // A zero period refreshes on every tick, as does a period of one.
      if (refresh_count + 1 >= refresh_period) begin
        held_sum      = running_sum;
        refresh_count = 0;
      end else begin
        refresh_count++;
      end

      if (hold_running && hold_timer < TimerMax) hold_timer++;

      nxt = state;
      case (state)
        StInit: begin
          relief    = 1'b0;
          emergency = 1'b0;
          if (state_timer > init_hold) nxt = StWait;
        end
        StWait: begin
          relief = 1'b0;
          if (master) nxt = StCheck;
        end
        StCheck: begin
          nxt = (held_sum >= low_sum) ? StOper : StEntry;
        end
        StOper: begin
          ign = req && en && !emergency;
          if (!master) nxt = StFault;
          else if (held_sum < low_sum) nxt = StEntry;
        end
        StEntry: begin
          relief    = 1'b1;
          emergency = 1'b1;
          if (state_timer > entry_hold) nxt = StActive;
        end
        StActive: begin
          relief    = 1'b1;
          emergency = 1'b1;
          if (held_sum <= safe_sum) nxt = StDepr;
        end
        StDepr: begin
          relief = 1'b1;
          if (held_sum <= safe_sum && master) begin
            if (!hold_running) begin
              hold_running = 1'b1;
              hold_timer   = 0;
            end
            if (hold_timer > vent_hold) nxt = StRecov;
          end
        end
        StRecov: begin
          relief    = 1'b0;
          emergency = 1'b0;
          if (state_timer > recov_hold) nxt = StWait;
        end
        StFault: begin
          relief = 1'b1;
          if (master) begin
            if (!hold_running) begin
              hold_running = 1'b1;
              hold_timer   = 0;
            end
            if (hold_timer > fault_hold) nxt = StWait;
          end
        end
        default: nxt = StInit;
      endcase

      // Any change of state restarts both timers.
      if (nxt != state) begin
        state        = nxt;
        state_timer  = 0;
        hold_running = 1'b0;
        hold_timer   = 0;
      end else if (state_timer < TimerMax) begin
        state_timer++;
      end

      o.state_code   = state;
      o.relief_open  = relief;
      o.ignition_on  = ign;
      o.emerg_flag   = emergency;
      o.filtered_sum = held_sum[SumW-1:0];
      outputs_due.push_back(o);
    endfunction

    function void compare(string field, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      end
    endfunction

    // Checks one result item against the oldest prediction.
    function void check_output(logic [23:0] data);
      tick_output_t exp_o;
      if (outputs_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result item, expected none, actual 0x%06h", $time, data);
        return;
      end
      exp_o = outputs_due.pop_front();
      compare("state_code", exp_o.state_code, data[3:0]);
      compare("relief_open", exp_o.relief_open, data[4]);
      compare("ignition_on", exp_o.ignition_on, data[5]);
      compare("emerg_flag", exp_o.emerg_flag, data[6]);
      compare("filtered_sum", exp_o.filtered_sum, data[19:7]);
    endfunction
  endclass

endpackage

// ----- tb/tb_brake_pressure_safety_sequencer_core.sv -----
`timescale 1ns / 1ps

module tb_brake_pressure_safety_sequencer_core;
  import bpss_pkg::*;
  import bpss_tb_pkg::*;

  typedef enum int unsigned {LvlZero, LvlLow, LvlHigh, LvlFull, LvlAny} level_mode_e;
  typedef enum int unsigned {RdyOpen, RdyRandom, RdyPulsed, RdyHold} ready_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  // [0] master_switch, [1] ignition_request, [2] ignition_enable,
  // [12:3] pressure_sample, [15:13] zero
  logic [15:0]         s_axis_tdata_i;
  // [0] sample_valid
  logic                s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  // [3:0] state_code, [4] relief_open, [5] ignition_on, [6] emerg_flag,
  // [19:7] filtered_sum, [23:20] zero
  logic [23:0]         m_axis_tdata_o;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  sequencer_scoreboard sb;

  // Stretches of pressure level and master switch for the random ticks.
  level_mode_e level_mode;
  int unsigned level_left;
  int unsigned master_left;
  bit          master_level;

  brake_pressure_safety_sequencer_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both handshakes are observed at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_tick(s_axis_tdata_i[0], s_axis_tdata_i[1], s_axis_tdata_i[2],
                     s_axis_tuser_i, s_axis_tdata_i[12:3]);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_output(m_axis_tdata_o);
    end
  end

  // The result side stalls on a mix of open, random, pulsed and held patterns.
  initial begin
    ready_mode_e rmode;
    int unsigned span;
    int unsigned lo_len;
    int unsigned hi_len;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      rmode  = ready_mode_e'($urandom_range(0, 3));
      span   = $urandom_range(20, 100);
      lo_len = $urandom_range(1, 4);
      hi_len = $urandom_range(1, 4);
      case (rmode)
        RdyOpen: begin
          repeat (span) begin
            @(negedge clk_i);
            m_axis_tready_i <= 1'b1;
          end
        end
        RdyRandom: begin
          repeat (span) begin
            @(negedge clk_i);
            m_axis_tready_i <= $urandom_range(0, 1);
          end
        end
        RdyPulsed: begin
          repeat (span / (lo_len + hi_len) + 1) begin
            repeat (lo_len) begin
              @(negedge clk_i);
              m_axis_tready_i <= 1'b0;
            end
            repeat (hi_len) begin
              @(negedge clk_i);
              m_axis_tready_i <= 1'b1;
            end
          end
        end
        default: begin
          repeat ($urandom_range(1, 6)) begin
            @(negedge clk_i);
            m_axis_tready_i <= 1'b0;
          end
        end
      endcase
    end
  end

  initial begin
    #60_000_000;
    $display("brake_pressure_safety_sequencer_core verification failed");
    $finish;
  end

  function automatic cfg_t make_cfg(int unsigned low, int unsigned safe, int unsigned refresh,
                                    int unsigned init_h, int unsigned entry_h,
                                    int unsigned vent_h, int unsigned recov_h,
                                    int unsigned fault_h);
    cfg_t c;
    c.low_sum        = SumW'(low);
    c.safe_sum       = SumW'(safe);
    c.refresh_period = PeriodW'(refresh);
    c.init_hold      = TimerW'(init_h);
    c.entry_hold     = TimerW'(entry_h);
    c.vent_hold      = TimerW'(vent_h);
    c.recov_hold     = TimerW'(recov_h);
    c.fault_hold     = TimerW'(fault_h);
    return c;
  endfunction

  // Thresholds spread over the useful range, short entry, vent, recovery and fault holds so the states keep cycling.
  function automatic cfg_t random_cfg();
    int unsigned refresh;
    refresh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
    return make_cfg($urandom_range(600, 7000), $urandom_range(0, 3000), refresh,
                    $urandom_range(0, 65535), $urandom_range(0, 24), $urandom_range(0, 24),
                    $urandom_range(0, 24), $urandom_range(0, 24));
  endfunction

  function automatic void make_random_tick(output bit master, output bit req, output bit en,
                                           output bit valid,
                                           output logic [SampleW-1:0] sample);
    if (level_left == 0) begin
      level_mode = level_mode_e'($urandom_range(0, 4));
      level_left = $urandom_range(4, 40);
    end
    level_left--;
    if (master_left == 0) begin
      master_level = ($urandom_range(0, 7) != 0);
      master_left  = $urandom_range(2, 30);
    end
    master_left--;
    case (level_mode)
      LvlZero: sample = '0;
      LvlLow:  sample = $urandom_range(0, 63);
      LvlHigh: sample = $urandom_range(900, 1023);
      LvlFull: sample = AdcMax;
      default: sample = $urandom_range(0, 1023);
    endcase
    // An odd glitch on the master switch breaks up the well-formed runs.
    master = master_level ^ ($urandom_range(0, 19) == 0);
    req    = $urandom_range(0, 1);
    en     = $urandom_range(0, 1);
    valid  = ($urandom_range(0, 6) != 0);
  endfunction

  task automatic write_register(input logic [CfgAddrW-1:0] idx,
                                input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    sb.set_register(idx, val);
  endtask

  task automatic apply_cfg(input cfg_t c);
    write_register(CfgLowSum, CfgDataW'(c.low_sum));
    write_register(CfgSafeSum, CfgDataW'(c.safe_sum));
    write_register(CfgRefresh, CfgDataW'(c.refresh_period));
    write_register(CfgInitHold, c.init_hold);
    write_register(CfgEntryHold, c.entry_hold);
    write_register(CfgVentHold, c.vent_hold);
    write_register(CfgRecovHold, c.recov_hold);
    write_register(CfgFaultHold, c.fault_hold);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Called just after a falling edge; returns once the item has been accepted.
  task automatic send_tick(input bit master, input bit req, input bit en, input bit valid,
                           input logic [SampleW-1:0] sample);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, sample, en, req, master};
    s_axis_tuser_i  <= valid;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic lower_valid(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
    end
  endtask

  // Waits until every predicted output has arrived, then lets the pipeline settle.
  task automatic drain_outputs();
    do @(negedge clk_i); while (sb.pending() != 0);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic run_random_phase(input int unsigned n_ticks, input bit with_gaps);
    int unsigned        burst_left;
    int unsigned        pause_at;
    bit                 m;
    bit                 r;
    bit                 e;
    bit                 v;
    logic [SampleW-1:0] smp;
    burst_left = 0;
    pause_at   = $urandom_range(n_ticks / 4, (3 * n_ticks) / 4);
    for (int unsigned i = 0; i < n_ticks; i++) begin
      // Once per phase the sender holds off until the block has caught up.
      if (i == pause_at) begin
        lower_valid(1);
        drain_outputs();
      end
      if (with_gaps && burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) lower_valid($urandom_range(1, 8));
        burst_left = $urandom_range(1, 32);
      end
      @(negedge clk_i);
      make_random_tick(m, r, e, v, smp);
      send_tick(m, r, e, v, smp);
      if (burst_left != 0) burst_left--;
    end
    lower_valid(1);
  endtask

  initial begin
    cfg_t               cfg;
    bit                 m;
    logic [SampleW-1:0] smp;
    sb              = new();
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_addr_i      = '0;
    cfg_wdata_i     = '0;
    level_mode      = LvlAny;
    level_left      = 0;
    master_left     = 0;
    master_level    = 1'b1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed ticks: full-scale and empty samples, alternating bit patterns, every
    // request and enable pair, a master switch drop and the filter before its first
    // refresh.
    apply_cfg(make_cfg(1500, 300, 3, 2, 2, 2, 2, 2));
    for (int i = 0; i < 24; i++) begin
      if (i < 10) smp = AdcMax;
      else if (i < 18) smp = '0;
      else smp = (i % 2 == 1) ? 10'h155 : 10'h2AA;
      @(negedge clk_i);
      send_tick(i != 13 && i != 14, i[0], i[1], (i % 5) != 4, smp);
    end
    lower_valid(1);

    // All registers at their lowest, then at their highest values.
    drain_outputs();
    apply_cfg(make_cfg(0, 0, 0, 0, 0, 0, 0, 0));
    run_random_phase(80, 1'b1);
    drain_outputs();
    apply_cfg(make_cfg(8191, 8191, 511, 65535, 65535, 65535, 65535, 65535));
    run_random_phase(60, 1'b1);

    for (int phase = 0; phase < 6; phase++) begin
      drain_outputs();
      apply_cfg(random_cfg());
      run_random_phase($urandom_range(60, 100), 1'b1);
    end

    // Steer into fault with a hold that never ends and keep ticking there.
    drain_outputs();
    apply_cfg(make_cfg(2000, 500, 1, 0, 3, 3, 3, 65535));
    for (int k = 0; k < 4000; k++) begin
      @(negedge clk_i);
      if (sb.state == StFault) begin
        s_axis_tvalid_i <= 1'b0;
        break;
      end
      case (sb.state)
        StOper:                  send_tick(1'b0, 1'b0, 1'b0, 1'b1, AdcMax);
        StEntry, StActive, StDepr: send_tick(1'b1, 1'b0, 1'b0, 1'b1, '0);
        StWait: begin
          // Only go on to the check once the filtered sum is at or above the threshold.
          m = (sb.held_sum >= sb.low_sum);
          send_tick(m, 1'b0, 1'b0, 1'b1, AdcMax);
        end
        default:                 send_tick(1'b1, 1'b0, 1'b0, 1'b1, AdcMax);
      endcase
    end
    run_random_phase(60, 1'b0);

    // A fault hold one short of the maximum.
    drain_outputs();
    cfg = random_cfg();
    cfg.fault_hold = TimerW'(65534);
    apply_cfg(cfg);
    run_random_phase(80, 1'b1);

    drain_outputs();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("brake_pressure_safety_sequencer_core verification clean");
    end else begin
      if (sb.pending() != 0)
        $display("%0t: %0d expected result items never arrived", $time, sb.pending());
      $display("brake_pressure_safety_sequencer_core verification failed");
    end
    $finish;
  end

endmodule
